FILE: rtl/framed_packet_checker_core_defines.svh
// ----------------------------------------------------------------------------
// Framed packet checker - assertion macros
// Concurrent assertion wrappers, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef FRAMED_PACKET_CHECKER_CORE_DEFINES_SVH
`define FRAMED_PACKET_CHECKER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked only outside reset
`define FPC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included
`define FPC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FPC_ASSERT(lbl, prop, msg)
`define FPC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: rtl/fpc_pkg.sv
// ----------------------------------------------------------------------------
// fpc_pkg
// Shared constants and types of the framed packet checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fpc_pkg;

    localparam logic [7:0] START_BYTE   = 8'hAA;
    localparam logic [7:0] TRAILER_BYTE = 8'h55;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_TRAIL = 2'd1;
    localparam logic [1:0] ST_BAD_SUM   = 2'd2;

    localparam int unsigned TDATA_IN_W  = 8;
    localparam int unsigned TDATA_OUT_W = 16;

    typedef struct packed {
        logic       valid;
        logic       ok;
        logic [1:0] status;
        logic [7:0] length;
    } fpc_result_t;

endpackage

FILE: rtl/fpc_frame_fsm.sv
// ----------------------------------------------------------------------------
// fpc_frame_fsm
// Frame parser: hunts for the start byte, counts payload, sums it, compares the
// checksum and judges the trailer. One byte per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpc_frame_fsm
    import fpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  rx_byte,
    output fpc_result_t res
);

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_LENGTH  = 3'd1;
    localparam logic [2:0] PH_PAYLOAD = 3'd2;
    localparam logic [2:0] PH_CHKSUM  = 3'd3;
    localparam logic [2:0] PH_TRAILER = 3'd4;

    logic [2:0] phase_reg, phase_next;
    logic [7:0] left_reg, left_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] length_reg, length_next;
    logic       matched_reg, matched_next;

    always_comb
    begin
        phase_next   = phase_reg;
        left_next    = left_reg;
        sum_next     = sum_reg;
        length_next  = length_reg;
        matched_next = matched_reg;
        if (step)
        begin
            case (phase_reg)
                PH_LENGTH:
                begin
                    length_next = rx_byte;
                    left_next   = rx_byte;
                    sum_next    = 8'd0;
                    phase_next  = (rx_byte == 8'd0) ? PH_CHKSUM : PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    sum_next  = sum_reg + rx_byte;
                    left_next = left_reg - 8'd1;
                    if (left_reg == 8'd1)
                    begin
                        phase_next = PH_CHKSUM;
                    end
                end
                PH_CHKSUM:
                begin
                    matched_next = (rx_byte == sum_reg);
                    phase_next   = PH_TRAILER;
                end
                PH_TRAILER:
                begin
                    phase_next = PH_IDLE;
                    left_next  = 8'd0;
                end
                default:
                begin
                    // unused codes behave as idle
                    phase_next = (rx_byte == START_BYTE) ? PH_LENGTH : PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            left_reg    <= 8'd0;
            sum_reg     <= 8'd0;
            length_reg  <= 8'd0;
            matched_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            left_reg    <= left_next;
            sum_reg     <= sum_next;
            length_reg  <= length_next;
            matched_reg <= matched_next;
        end
    end

    // trailer beats checksum
    always_comb
    begin
        res.valid = (phase_reg == PH_TRAILER);
        if (rx_byte != TRAILER_BYTE)
        begin
            res.status = ST_BAD_TRAIL;
        end
        else if (!matched_reg)
        begin
            res.status = ST_BAD_SUM;
        end
        else
        begin
            res.status = ST_OK;
        end
        res.ok     = (res.status == ST_OK);
        res.length = length_reg;
    end

endmodule

FILE: rtl/framed_packet_checker_core.sv
// ----------------------------------------------------------------------------
// framed_packet_checker_core
// Additive checksum frame checker on a byte stream.
// ----------------------------------------------------------------------------
// Input channel s_axis: one received byte per item. Frames are 0xAA, length,
// payload, checksum (sum of payload mod 256), 0x55. Bytes outside a frame are
// dropped without a result.
// Output channel m_axis: one item per frame, issued for the trailer byte,
// carrying the ok flag, the status code and the frame's length byte.
// Path: the accepting edge loads the byte into the input register; its result is
// then loaded into the output register, which drives m_axis_tvalid and holds
// the result until it is taken.
// Throughput: one byte per cycle; each byte needs one 8-bit add and compare.
// A result waiting in the output register does not stop payload bytes; only a
// trailer byte waits while the output register is full and not being taken,
// and then the input register holds and s_axis_tready falls.
// Reset: the parser returns to hunting for the start byte and both registers
// are emptied.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "framed_packet_checker_core_defines.svh"

module framed_packet_checker_core
    import fpc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [TDATA_IN_W-1:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [TDATA_OUT_W-1:0] m_axis_tdata    // [0] frame_ok, [2:1] frame_status,
                                                   // [10:3] payload_length, rest zero
);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              out_valid_reg;
    logic              out_ok_reg;
    logic [1:0]        out_status_reg;
    logic [7:0]        out_length_reg;
    fpc_result_t       res;
    logic              out_free;
    logic              advance;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && (!res.valid || out_free);
    assign s_axis_tready = !in_valid_reg || advance;

    fpc_frame_fsm u_fsm (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance && res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.valid)
        begin
            out_ok_reg     <= res.ok;
            out_status_reg <= res.status;
            out_length_reg <= res.length;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_length_reg, out_status_reg, out_ok_reg};

    `FPC_ASSERT(a_ok_matches_status, m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[2:1] == ST_OK)), "frame_ok disagrees with frame_status")
    `FPC_ASSERT(a_status_legal, m_axis_tvalid |-> (m_axis_tdata[2:1] != 2'd3), "illegal frame_status code")
    `FPC_ASSERT(a_stalled_byte_held, (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)), "stalled input byte lost")
    `FPC_ASSERT_ALWAYS(a_pad_zero, m_axis_tdata[15:11] == 5'd0, "tdata padding not zero")

endmodule
